>>> hw/rtl/butterworth_lowpass_biquad_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Butterworth low-pass biquad
// Clocked property shorthands with reset disable, same-cycle and next-cycle.
// ---------------------------------------------------------------------------
`ifndef BUTTERWORTH_LOWPASS_BIQUAD_TOP_ASSERT_SVH
`define BUTTERWORTH_LOWPASS_BIQUAD_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define BWL_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bwl same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define BWL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bwl next-cycle check failed");

`endif

>>> hw/rtl/bwl_pkg.sv
// ---------------------------------------------------------------------------
// bwl_pkg
// Shared widths, constants, command codes and control structs of the biquad.
// ---------------------------------------------------------------------------
`default_nettype none

package bwl_pkg;

  // widths
  localparam int unsigned SampleWidth = 32;
  localparam int unsigned TDataW      = ((SampleWidth + 7) / 8) * 8;
  localparam int unsigned CfgW        = 32;
  localparam int unsigned CoefW       = 32;
  localparam int unsigned XW          = 48;
  localparam int unsigned MulW        = ((SampleWidth > CoefW) ? SampleWidth : CoefW) + 1;
  localparam int unsigned ProdW       = 2 * MulW;
  localparam int unsigned WideW       = 128;
  localparam int unsigned RemW        = 96;
  localparam int unsigned QuoW        = 33;
  localparam int unsigned FracDrop    = 30;

  // register indexes
  localparam logic RegCutoff = 1'b0;
  localparam logic RegPeriod = 1'b1;
  localparam logic [CfgW-1:0] CutoffReset = 32'd6553600;
  localparam logic [CfgW-1:0] PeriodReset = 32'd4294967;

  // input kinds
  localparam logic [1:0] KindSample  = 2'd0;
  localparam logic [1:0] KindClear   = 2'd1;
  localparam logic [1:0] KindPreload = 2'd2;

  // coefficient constants
  localparam logic [31:0] K2500 = 32'd2500;
  localparam logic [31:0] K7071 = 32'd7071;
  localparam logic [WideW-1:0] KC = {64'd10000, 64'd0};
  localparam logic [WideW-1:0] KT = {64'd20000, 64'd0};

  // multiplier operand selects
  localparam logic [3:0] MsCp  = 4'd0;
  localparam logic [3:0] MsLl  = 4'd1;
  localparam logic [3:0] MsLh  = 4'd2;
  localparam logic [3:0] MsHh  = 4'd3;
  localparam logic [3:0] MsW0  = 4'd4;
  localparam logic [3:0] MsW1  = 4'd5;
  localparam logic [3:0] MsW2  = 4'd6;
  localparam logic [3:0] MsXl7 = 4'd7;
  localparam logic [3:0] MsXh7 = 4'd8;
  localparam logic [3:0] MsF0  = 4'd9;
  localparam logic [3:0] MsF1  = 4'd10;
  localparam logic [3:0] MsF2  = 4'd11;
  localparam logic [3:0] MsF3  = 4'd12;
  localparam logic [3:0] MsF4  = 4'd13;

  // store selects
  localparam logic [2:0] SsNone = 3'd0;
  localparam logic [2:0] SsX    = 3'd1;
  localparam logic [2:0] SsX2   = 3'd2;
  localparam logic [2:0] SsA    = 3'd3;
  localparam logic [2:0] SsB    = 3'd4;
  localparam logic [2:0] SsDen  = 3'd5;

  // divider ops
  localparam logic [2:0] DvNone  = 3'd0;
  localparam logic [2:0] DvLoad  = 3'd1;
  localparam logic [2:0] DvShift = 3'd2;
  localparam logic [2:0] DvInit  = 3'd3;
  localparam logic [2:0] DvStep  = 3'd4;
  localparam logic [2:0] DvStore = 3'd5;

  // history ops
  localparam logic [1:0] HsNone  = 2'd0;
  localparam logic [1:0] HsClr   = 2'd1;
  localparam logic [1:0] HsLoad  = 2'd2;
  localparam logic [1:0] HsShift = 2'd3;

  typedef struct packed {
    logic       mul_en;
    logic [3:0] mul_sel;
    logic       acc_clr;
    logic       acc_rnd;
    logic       acc_add;
    logic [1:0] acc_wsh;
    logic [2:0] st_sel;
    logic [2:0] dv_op;
    logic [1:0] dv_idx;
    logic [1:0] hs_op;
    logic       smp_ld;
    logic       out_ld;
  } bwl_cmd_t;

  typedef struct packed {
    logic norm_done;
    logic out_busy;
  } bwl_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/butterworth_lowpass_biquad_top.sv
// ---------------------------------------------------------------------------
// butterworth_lowpass_biquad_top
// Second-order Butterworth low-pass, direct form I, coefficients derived
// on chip from the cutoff and sample-period registers.
// ---------------------------------------------------------------------------
// channel   dir  handshake             payload
// s_axis    in   tvalid/tready         tdata: value, tuser: kind
// m_axis    out  tvalid/tready         tdata: filtered
// cfg       in   cfg_we_i              cfg_idx_i, cfg_data_i
//
// A sample beat runs through the accept cycle, six multiply and accumulate
// steps and one saturate-and-load step into the output register, which a
// waiting result stalls; tready is low meanwhile. Clear and preload beats
// are taken at accept, no result. After reset and each register write the
// coefficients are rederived, tready low: a program, then per coefficient a
// load, up to 12 denominator shifts, quotient steps and a store.
// ---------------------------------------------------------------------------
`default_nettype none

module butterworth_lowpass_biquad_top
  import bwl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [TDataW-1:0] s_axis_tdata,   // [SampleWidth-1:0] value
  input  logic [1:0]        s_axis_tuser,   // [1:0] kind
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [TDataW-1:0] m_axis_tdata,   // [SampleWidth-1:0] filtered
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CfgW-1:0]   cfg_data_i
);

  bwl_cmd_t               cmd;
  bwl_sts_t               sts;
  logic [SampleWidth-1:0] out_data;

  bwl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bwl_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_value_i  (s_axis_tdata[SampleWidth-1:0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_data)
  );

  assign m_axis_tdata = TDataW'(out_data);

endmodule

`default_nettype wire

>>> hw/rtl/bwl_ctrl.sv
// ---------------------------------------------------------------------------
// bwl_ctrl
// Sequencer: coefficient derivation program, divider loop and filter steps.
// ---------------------------------------------------------------------------
`default_nettype none

module bwl_ctrl
  import bwl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       in_valid_i,
  input  logic [1:0] in_kind_i,
  output logic       in_ready_o,
  input  bwl_sts_t   sts_i,
  output bwl_cmd_t   cmd_o
);

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StDrv    = 4'd1;
  localparam logic [3:0] StDLoad  = 4'd2;
  localparam logic [3:0] StDShift = 4'd3;
  localparam logic [3:0] StDInit  = 4'd4;
  localparam logic [3:0] StDStep  = 4'd5;
  localparam logic [3:0] StDStore = 4'd6;
  localparam logic [3:0] StFilt   = 4'd7;
  localparam logic [3:0] StFin    = 4'd8;

  localparam logic [4:0] DrvLast  = 5'd18;
  localparam logic [4:0] DivLast  = 5'd31;
  localparam logic [4:0] FiltLast = 5'd5;
  localparam logic [1:0] CoefLast = 2'd3;

  logic [3:0] state_q, state_d;
  logic [4:0] step_q, step_d;
  logic [1:0] didx_q, didx_d;
  bwl_cmd_t   cmd;

  // next state and command decode
  always_comb begin
    cmd     = '0;
    state_d = state_q;
    step_d  = step_q;
    didx_d  = didx_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          case (in_kind_i)
            KindSample: begin
              cmd.smp_ld  = 1'b1;
              cmd.acc_clr = 1'b1;
              cmd.acc_rnd = 1'b1;
              step_d      = '0;
              state_d     = StFilt;
            end
            KindClear:   cmd.hs_op = HsClr;
            KindPreload: cmd.hs_op = HsLoad;
            default: ;
          endcase
        end
      end
      StDrv: begin
        // x, x^2, a = 2500 x^2, b = 7071 x << 32, den
        case (step_q)
          5'd0:  begin cmd.acc_clr = 1'b1; cmd.mul_en = 1'b1; cmd.mul_sel = MsCp; end
          5'd1:  cmd.acc_add = 1'b1;
          5'd2:  cmd.st_sel = SsX;
          5'd3:  begin cmd.acc_clr = 1'b1; cmd.mul_en = 1'b1; cmd.mul_sel = MsLl; end
          5'd4:  begin cmd.acc_add = 1'b1; cmd.mul_en = 1'b1; cmd.mul_sel = MsLh; end
          5'd5:  begin
            cmd.acc_add = 1'b1; cmd.acc_wsh = 2'd1; cmd.mul_en = 1'b1; cmd.mul_sel = MsLh;
          end
          5'd6:  begin
            cmd.acc_add = 1'b1; cmd.acc_wsh = 2'd1; cmd.mul_en = 1'b1; cmd.mul_sel = MsHh;
          end
          5'd7:  begin cmd.acc_add = 1'b1; cmd.acc_wsh = 2'd2; end
          5'd8:  cmd.st_sel = SsX2;
          5'd9:  begin cmd.acc_clr = 1'b1; cmd.mul_en = 1'b1; cmd.mul_sel = MsW0; end
          5'd10: begin cmd.acc_add = 1'b1; cmd.mul_en = 1'b1; cmd.mul_sel = MsW1; end
          5'd11: begin
            cmd.acc_add = 1'b1; cmd.acc_wsh = 2'd1; cmd.mul_en = 1'b1; cmd.mul_sel = MsW2;
          end
          5'd12: begin cmd.acc_add = 1'b1; cmd.acc_wsh = 2'd2; end
          5'd13: cmd.st_sel = SsA;
          5'd14: begin cmd.acc_clr = 1'b1; cmd.mul_en = 1'b1; cmd.mul_sel = MsXl7; end
          5'd15: begin cmd.acc_add = 1'b1; cmd.mul_en = 1'b1; cmd.mul_sel = MsXh7; end
          5'd16: begin cmd.acc_add = 1'b1; cmd.acc_wsh = 2'd1; end
          5'd17: cmd.st_sel = SsB;
          5'd18: cmd.st_sel = SsDen;
          default: ;
        endcase
        if (step_q == DrvLast) begin
          didx_d  = '0;
          state_d = StDLoad;
        end else begin
          step_d = step_q + 5'd1;
        end
      end
      StDLoad: begin
        cmd.dv_op  = DvLoad;
        cmd.dv_idx = didx_q;
        state_d    = StDShift;
      end
      StDShift: begin
        if (sts_i.norm_done) state_d = StDInit;
        else cmd.dv_op = DvShift;
      end
      StDInit: begin
        cmd.dv_op = DvInit;
        step_d    = '0;
        state_d   = StDStep;
      end
      StDStep: begin
        cmd.dv_op = DvStep;
        if (step_q == DivLast) state_d = StDStore;
        else step_d = step_q + 5'd1;
      end
      StDStore: begin
        cmd.dv_op  = DvStore;
        cmd.dv_idx = didx_q;
        if (didx_q == CoefLast) begin
          state_d = StIdle;
        end else begin
          didx_d  = didx_q + 2'd1;
          state_d = StDLoad;
        end
      end
      StFilt: begin
        // issue product k, accumulate product k-1
        cmd.acc_add = (step_q != 5'd0);
        cmd.mul_en  = (step_q != FiltLast);
        case (step_q)
          5'd0:    cmd.mul_sel = MsF0;
          5'd1:    cmd.mul_sel = MsF1;
          5'd2:    cmd.mul_sel = MsF2;
          5'd3:    cmd.mul_sel = MsF3;
          default: cmd.mul_sel = MsF4;
        endcase
        if (step_q == FiltLast) state_d = StFin;
        else step_d = step_q + 5'd1;
      end
      StFin: begin
        if (!sts_i.out_busy) begin
          cmd.out_ld = 1'b1;
          cmd.hs_op  = HsShift;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    // any register write restarts the derivation
    if (cfg_we_i) begin
      state_d = StDrv;
      step_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StDrv;
      step_q  <= '0;
      didx_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      didx_q  <= didx_d;
    end
  end

  assign in_ready_o = (state_q == StIdle);
  assign cmd_o      = cmd;

endmodule

`default_nettype wire

>>> hw/rtl/bwl_datapath.sv
// ---------------------------------------------------------------------------
// bwl_datapath
// Config registers, shared multiplier, accumulator, divider and histories.
// ---------------------------------------------------------------------------
`default_nettype none

module bwl_datapath
  import bwl_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [CfgW-1:0]        cfg_data_i,
  input  logic [SampleWidth-1:0] in_value_i,
  input  bwl_cmd_t               cmd_i,
  output bwl_sts_t               sts_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SampleWidth-1:0] out_data_o
);

  localparam logic [WideW-1:0] RoundInit = WideW'(1) << (FracDrop - 1);
  localparam logic signed [WideW-1:0] SMax =
    WideW'((WideW'(1) << (SampleWidth - 1)) - WideW'(1));
  localparam logic signed [WideW-1:0] SMin = -SMax - WideW'(1);
  localparam logic [QuoW-1:0] QNegLim = QuoW'(1) << (CoefW - 1);
  localparam logic [QuoW-1:0] QPosLim = (QuoW'(1) << (CoefW - 1)) - QuoW'(1);

  logic [CfgW-1:0]        cutoff_q, period_q;
  logic [XW-1:0]          x_q;
  logic [RemW-1:0]        x2_q;
  logic [WideW-1:0]       a_q, b_q, den_q;
  logic [WideW-1:0]       dreg_q, nreg_q;
  logic                   neg_q;
  logic [RemW-1:0]        rem_q;
  logic [31:0]            lw_q;
  logic [QuoW-1:0]        quo_q;
  logic [CoefW-1:0]       coef_q [5];
  logic [SampleWidth-1:0] u_q, i1_q, i2_q, o1_q, o2_q;
  logic signed [ProdW-1:0] prod_q;
  logic [WideW-1:0]       acc_q;
  logic [SampleWidth-1:0] out_q;
  logic                   out_valid_q;

  function automatic logic signed [MulW-1:0] zx(input logic [31:0] v);
    return $signed({{(MulW - 32){1'b0}}, v});
  endfunction

  function automatic logic signed [MulW-1:0] sxc(input logic [CoefW-1:0] v);
    return $signed({{(MulW - CoefW){v[CoefW-1]}}, v});
  endfunction

  function automatic logic signed [MulW-1:0] sxs(input logic [SampleWidth-1:0] v);
    return $signed({{(MulW - SampleWidth){v[SampleWidth-1]}}, v});
  endfunction

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= CutoffReset;
      period_q <= PeriodReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegCutoff) cutoff_q <= cfg_data_i;
      else period_q <= cfg_data_i;
    end
  end

  // shared multiplier operand select
  logic [31:0] xl;
  logic [31:0] xh;
  logic signed [MulW-1:0] op_a, op_b;
  assign xl = x_q[31:0];
  assign xh = {{(64 - XW){1'b0}}, x_q[XW-1:32]};

  always_comb begin
    case (cmd_i.mul_sel)
      MsCp:    begin op_a = zx(cutoff_q);     op_b = zx(period_q); end
      MsLl:    begin op_a = zx(xl);           op_b = zx(xl); end
      MsLh:    begin op_a = zx(xl);           op_b = zx(xh); end
      MsHh:    begin op_a = zx(xh);           op_b = zx(xh); end
      MsW0:    begin op_a = zx(x2_q[31:0]);   op_b = zx(K2500); end
      MsW1:    begin op_a = zx(x2_q[63:32]);  op_b = zx(K2500); end
      MsW2:    begin op_a = zx(x2_q[95:64]);  op_b = zx(K2500); end
      MsXl7:   begin op_a = zx(xl);           op_b = zx(K7071); end
      MsXh7:   begin op_a = zx(xh);           op_b = zx(K7071); end
      MsF0:    begin op_a = sxc(coef_q[0]);   op_b = sxs(u_q); end
      MsF1:    begin op_a = sxc(coef_q[1]);   op_b = sxs(i1_q); end
      MsF2:    begin op_a = sxc(coef_q[2]);   op_b = sxs(i2_q); end
      MsF3:    begin op_a = sxc(coef_q[3]);   op_b = sxs(o1_q); end
      default: begin op_a = sxc(coef_q[4]);   op_b = sxs(o2_q); end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) prod_q <= ProdW'(op_a) * ProdW'(op_b);
  end

  // accumulator, product shifted by whole words
  logic [WideW-1:0] prod_ext, prod_sh;
  assign prod_ext = {{(WideW - ProdW){prod_q[ProdW-1]}}, prod_q};

  always_comb begin
    case (cmd_i.acc_wsh)
      2'd1:    prod_sh = {prod_ext[WideW-33:0], 32'd0};
      2'd2:    prod_sh = {prod_ext[WideW-65:0], 64'd0};
      default: prod_sh = prod_ext;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) acc_q <= cmd_i.acc_rnd ? RoundInit : '0;
    else if (cmd_i.acc_add) acc_q <= acc_q + prod_sh;
  end

  // intermediate stores of the derivation
  always_ff @(posedge clk_i) begin
    case (cmd_i.st_sel)
      SsX:   x_q   <= acc_q[63:16];
      SsX2:  x2_q  <= acc_q[RemW-1:0];
      SsA:   a_q   <= acc_q;
      SsB:   b_q   <= {acc_q[RemW-1:0], 32'd0};
      SsDen: den_q <= a_q + b_q + KC;
      default: ;
    endcase
  end

  // numerator magnitudes and signs
  logic [WideW-1:0] f_w, g_w, num_w;
  logic             neg_w;
  assign f_w = {a_q[WideW-2:0], 1'b0};
  assign g_w = a_q + KC;

  always_comb begin
    case (cmd_i.dv_idx)
      2'd0: begin num_w = a_q; neg_w = 1'b0; end
      2'd1: begin num_w = f_w; neg_w = 1'b0; end
      2'd2: begin
        if (KT >= f_w) begin num_w = KT - f_w; neg_w = 1'b0; end
        else begin num_w = f_w - KT; neg_w = 1'b1; end
      end
      default: begin
        if (g_w >= b_q) begin num_w = g_w - b_q; neg_w = 1'b1; end
        else begin num_w = b_q - g_w; neg_w = 1'b0; end
      end
    endcase
  end

  // restoring divider step
  logic [RemW:0] r2, dd, diff;
  logic          ge;
  assign r2   = {rem_q, lw_q[31]};
  assign dd   = {1'b0, dreg_q[RemW-1:0]};
  assign diff = r2 - dd;
  assign ge   = (r2 >= dd);

  // saturated Q2.30 coefficient
  logic [CoefW-1:0] coef_w;
  logic [QuoW-1:0]  quo_neg;
  assign quo_neg = -quo_q;

  always_comb begin
    if (neg_q) coef_w = (quo_q > QNegLim) ? QNegLim[CoefW-1:0] : quo_neg[CoefW-1:0];
    else coef_w = (quo_q > QPosLim) ? QPosLim[CoefW-1:0] : quo_q[CoefW-1:0];
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.dv_op)
      DvLoad: begin
        dreg_q <= den_q;
        nreg_q <= num_w;
        neg_q  <= neg_w;
      end
      DvShift: begin
        dreg_q <= dreg_q >> 1;
        nreg_q <= nreg_q >> 1;
      end
      DvInit: begin
        rem_q <= nreg_q[RemW+1:2];
        lw_q  <= {nreg_q[1:0], 30'd0};
        quo_q <= '0;
      end
      DvStep: begin
        rem_q <= ge ? diff[RemW-1:0] : r2[RemW-1:0];
        lw_q  <= {lw_q[30:0], 1'b0};
        quo_q <= {quo_q[QuoW-2:0], ge};
      end
      DvStore: begin
        case (cmd_i.dv_idx)
          2'd0: begin coef_q[0] <= coef_w; coef_q[2] <= coef_w; end
          2'd1: coef_q[1] <= coef_w;
          2'd2: coef_q[3] <= coef_w;
          default: coef_q[4] <= coef_w;
        endcase
      end
      default: ;
    endcase
  end

  // output rounding already in acc; shift and saturate
  logic signed [WideW-1:0] acc_sh;
  logic [SampleWidth-1:0]  y_w;
  assign acc_sh = $signed(acc_q) >>> FracDrop;

  always_comb begin
    if (acc_sh > SMax) y_w = SMax[SampleWidth-1:0];
    else if (acc_sh < SMin) y_w = SMin[SampleWidth-1:0];
    else y_w = acc_sh[SampleWidth-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.smp_ld) u_q <= in_value_i;
  end

  // past inputs and outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i1_q <= '0;
      i2_q <= '0;
      o1_q <= '0;
      o2_q <= '0;
    end else begin
      case (cmd_i.hs_op)
        HsClr: begin
          i1_q <= '0; i2_q <= '0; o1_q <= '0; o2_q <= '0;
        end
        HsLoad: begin
          i1_q <= in_value_i; i2_q <= in_value_i;
          o1_q <= in_value_i; o2_q <= in_value_i;
        end
        HsShift: begin
          i2_q <= i1_q; i1_q <= u_q; o2_q <= o1_q; o1_q <= y_w;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.out_ld) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) out_q <= y_w;
  end

  assign sts_o.norm_done = (dreg_q[WideW-1:RemW] == '0);
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/bwl_checker.sv
// ---------------------------------------------------------------------------
// bwl_checker
// Port-level checks of the biquad top, attached by bind.
// ---------------------------------------------------------------------------
`default_nettype none

`include "butterworth_lowpass_biquad_top_assert.svh"

module bwl_checker
  import bwl_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic [1:0]        s_axis_tuser,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [TDataW-1:0] m_axis_tdata,
  input logic              cfg_we_i
);

  logic out_stall;
  logic smp_acc;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign smp_acc   = s_axis_tvalid && s_axis_tready && (s_axis_tuser == KindSample);

  // stalled result beat holds
  `BWL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid)
  `BWL_ASSERT_NEXT(a_out_data, clk_i, rst_ni, out_stall, $stable(m_axis_tdata))

  // a sample beat keeps the input closed while it is filtered
  `BWL_ASSERT_NEXT(a_busy_smp, clk_i, rst_ni, smp_acc, !s_axis_tready)

  // a register write closes the input for the derivation
  `BWL_ASSERT_NEXT(a_busy_cfg, clk_i, rst_ni, cfg_we_i, !s_axis_tready)

endmodule

bind butterworth_lowpass_biquad_top bwl_checker u_bwl_checker (.*);

`default_nettype wire

>>> tb/tb_top.sv
// ---------------------------------------------------------------------------
// Butterworth low-pass biquad testbench
// Drives sample, clear, preload and unused beats through the stream ports
// under several coefficient settings and idle patterns. Each result beat is
// compared with a bit-exact model of the derived coefficients and the
// rounded, saturated filter sum, or with a fixed value in some directed rows.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import bwl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KindUnused = 2'd3;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned NumPhases = 7;
  localparam int unsigned ItemsPerPhase = 90;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [TDataW-1:0] s_axis_tdata = '0;
  logic [1:0]        s_axis_tuser = KindSample;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [TDataW-1:0] m_axis_tdata;
  logic              cfg_we_i = 1'b0;
  logic              cfg_idx_i = RegCutoff;
  logic [CfgW-1:0]   cfg_data_i = '0;

  butterworth_lowpass_biquad_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // model state
  logic [31:0] cutoff_reg, period_reg;
  longint      coef [5];
  longint      in_one, in_two, out_one, out_two;

  logic [31:0] filtered_q [$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned recv_hold = 0;
  int unsigned cycle_cnt = 0;

  // Q2.30 quotient of magnitudes, truncated, saturated by sign
  function automatic longint coef_ratio(logic [127:0] num, logic [127:0] den, bit neg);
    logic [127:0] n;
    logic [63:0]  q;
    while (den[127:96] != 0) begin
      den = den >> 1;
      num = num >> 1;
    end
    n = num << 30;
    q = 64'(n / den);
    if (neg) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return -longint'(q);
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return longint'(q);
  endfunction

  function automatic void derive_coefs();
    logic [63:0]  prod, x7;
    logic [127:0] x, x2, a, f, b, c, t, den, g;
    prod = {32'd0, cutoff_reg} * {32'd0, period_reg};
    x    = {64'd0, prod >> 16};
    x2   = x * x;
    a    = x2 * 128'd2500;
    f    = x2 * 128'd5000;
    x7   = x[63:0] * 64'd7071;
    b    = {32'd0, x7, 32'd0};
    c    = {64'd10000, 64'd0};
    t    = {64'd20000, 64'd0};
    den  = a + b + c;
    g    = a + c;
    coef[0] = coef_ratio(a, den, 1'b0);
    coef[1] = coef_ratio(f, den, 1'b0);
    coef[2] = coef[0];
    coef[3] = (t >= f) ? coef_ratio(t - f, den, 1'b0) : coef_ratio(f - t, den, 1'b1);
    coef[4] = (g >= b) ? coef_ratio(g - b, den, 1'b1) : coef_ratio(b - g, den, 1'b0);
  endfunction

  // one beat through the filter; returns 1 when a result is produced
  function automatic bit filter_step(logic [1:0] kind, logic [31:0] value,
                                     output logic [31:0] y);
    longint             u;
    logic signed [127:0] acc, sh;
    u = longint'($signed(value));
    y = '0;
    case (kind)
      KindClear: begin
        in_one = 0; in_two = 0; out_one = 0; out_two = 0;
        return 1'b0;
      end
      KindPreload: begin
        in_one = u; in_two = u; out_one = u; out_two = u;
        return 1'b0;
      end
      KindSample: begin
        acc = 128'(coef[0]) * 128'(u) + 128'(coef[1]) * 128'(in_one)
            + 128'(coef[2]) * 128'(in_two) + 128'(coef[3]) * 128'(out_one)
            + 128'(coef[4]) * 128'(out_two) + (128'sd1 <<< 29);
        sh = acc >>> 30;
        if (sh > 128'sd2147483647) sh = 128'sd2147483647;
        if (sh < -128'sd2147483648) sh = -128'sd2147483648;
        y = sh[31:0];
        in_two = in_one;
        in_one = u;
        out_two = out_one;
        out_one = longint'($signed(y));
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // offer one beat, predict it when accepted
  task automatic send_beat(logic [1:0] kind, logic [31:0] value,
                           bit fixed_en = 1'b0, logic [31:0] fixed = '0);
    logic [31:0] y;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (filter_step(kind, value, y))
      filtered_q.insert(filtered_q.size(), fixed_en ? fixed : y);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == RegCutoff) cutoff_reg = data;
    else period_reg = data;
    derive_coefs();
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3, 4: return 32'($urandom_range(32'h0010_0000) - 32'h0008_0000);
      default: return $urandom;
    endcase
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (recv_hold > 0) begin
      m_axis_tready <= 1'b0;
      recv_hold <= recv_hold - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (filtered_q.size() == 0) begin
        flag_mismatch("unexpected beat", m_axis_tdata[31:0], '0);
      end else begin
        if (m_axis_tdata[31:0] !== filtered_q[0])
          flag_mismatch("filtered", m_axis_tdata[31:0], filtered_q[0]);
        void'(filtered_q.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] value;
    bit          fixed_en;
    logic [31:0] fixed;
  } dir_row_t;

  dir_row_t dir_rows [] = '{
    '{KindSample,  32'h0000_0000, 1'b1, 32'h0},
    '{KindSample,  32'h7FFF_FFFF, 1'b0, 32'h0},
    '{KindSample,  32'h8000_0000, 1'b0, 32'h0},
    '{KindSample,  32'h0000_0001, 1'b0, 32'h0},
    '{KindSample,  32'hFFFF_FFFF, 1'b0, 32'h0},
    '{KindClear,   32'h0000_0000, 1'b0, 32'h0},
    '{KindSample,  32'h0000_0000, 1'b1, 32'h0},
    '{KindPreload, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{KindSample,  32'h7FFF_FFFF, 1'b0, 32'h0},
    '{KindSample,  32'h7FFF_FFFF, 1'b0, 32'h0},
    '{KindPreload, 32'h8000_0000, 1'b0, 32'h0},
    '{KindSample,  32'h8000_0000, 1'b0, 32'h0},
    '{KindUnused,  32'h0000_1234, 1'b0, 32'h0},
    '{KindSample,  32'h0001_0000, 1'b0, 32'h0},
    '{KindPreload, 32'h0000_0000, 1'b0, 32'h0},
    '{KindSample,  32'h0000_0000, 1'b1, 32'h0},
    '{KindUnused,  32'hFFFF_FFFF, 1'b0, 32'h0},
    '{KindClear,   32'hFFFF_FFFF, 1'b0, 32'h0},
    '{KindSample,  32'hFFFF_0000, 1'b0, 32'h0}
  };

  // coefficient settings per phase: reset values, then extremes, a larger cutoff and randoms
  logic [31:0] phase_cutoff [NumPhases];
  logic [31:0] phase_period [NumPhases];

  initial begin
    int unsigned k;
    logic [1:0]  kind;
    cutoff_reg = CutoffReset;
    period_reg = PeriodReset;
    in_one = 0; in_two = 0; out_one = 0; out_two = 0;
    derive_coefs();

    phase_cutoff = '{CutoffReset, 32'h0,         32'hFFFF_FFFF, 32'd32768000,
                     $urandom,    32'hFFFF_FFFF, 32'd1};
    phase_period = '{PeriodReset, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PeriodReset,
                     $urandom,    32'd1,         32'hFFFF_FFFF};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_beat(dir_rows[i].kind, dir_rows[i].value, dir_rows[i].fixed_en,
                dir_rows[i].fixed);
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      if (p != 0) begin
        write_reg(RegCutoff, phase_cutoff[p]);
        write_reg(RegPeriod, phase_period[p]);
        cfg_we_i <= 1'b0;
      end
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      // long receiver hold-off while the sender keeps offering
      if (p == 0 || p == 4) begin
        @(negedge clk_i);
        recv_hold = 400;
      end
      k = 0;
      while (k < ItemsPerPhase) begin
        case ($urandom_range(99)) inside
          [0:79]:  kind = KindSample;
          [80:85]: kind = KindClear;
          [86:93]: kind = KindPreload;
          default: kind = KindUnused;
        endcase
        send_beat(kind, rand_value());
        if (kind != KindUnused) k++;
      end
      drain();
    end

    if (mismatches == 0 && filtered_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
